@@ hw/rtl/tccs_pkg.sv @@
// Shared types, codes and defaults of the text console cursor and scroll block.
package tccs_pkg;

    // Default grid storage size.
    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;

    // Depth of the queues between the stages.
    localparam int QDEPTH = 2;

    // Reset values of the configuration registers.
    localparam logic [7:0] COLUMNS_RST = 8'd80;
    localparam logic [6:0] ROWS_RST    = 7'd48;

    // Configuration register indexes.
    localparam logic [0:0] REG_COLUMNS = 1'b0;
    localparam logic [0:0] REG_ROWS    = 1'b1;

    // Request function codes.
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    // Control characters.
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_BS  = 8'h08;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    // Operation decided by the front stage.
    typedef enum logic [2:0] {
        OP_READ,
        OP_IGNORE,
        OP_BACK,
        OP_NEWLINE,
        OP_PUT
    } t_op;

    // Back stage sequencer states.
    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_SCROLL,
        B_WIPE,
        B_FINISH
    } t_bstate;

    // Classified request passed from front to back.
    typedef struct packed {
        t_op        op;
        logic [7:0] code;
        logic [5:0] rrow;
        logic [6:0] rcol;
    } t_cmd;

    // Result of one request.
    typedef struct packed {
        logic [7:0] col;
        logic [5:0] row;
        logic [7:0] glyph;
        logic       scrolled;
    } t_res;

endpackage

@@ hw/rtl/tccs_fifo.sv @@
// Small register queue used between the stages and on the result side.
module tccs_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = tccs_pkg::QDEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [NW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and count update.
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : PW'(r_wp + 1'b1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : PW'(r_rp + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_cnt = NW'(r_cnt + 1'b1);
        end else if (do_pop && !do_push) begin
            n_cnt = NW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ hw/rtl/tccs_front.sv @@
// Front stage: accepts requests, classifies them and queues them for the back stage.
module tccs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_hold,
    input  logic           i_push,
    input  logic           i_func,
    input  logic [7:0]     i_char_code,
    input  logic [5:0]     i_read_row,
    input  logic [6:0]     i_read_col,
    output logic           o_full,
    input  logic           i_cmd_pop,
    output logic           o_cmd_empty,
    output tccs_pkg::t_cmd o_cmd
);

    tccs_pkg::t_cmd cmd;
    logic           q_full;
    logic           q_push;

    // Decide the operation from the function and the character.
    always_comb begin
        cmd.code = i_char_code;
        cmd.rrow = i_read_row;
        cmd.rcol = i_read_col;
        if (i_func == tccs_pkg::FUNC_READ) begin
            cmd.op = tccs_pkg::OP_READ;
        end else begin
            case (i_char_code)
                tccs_pkg::CHAR_NUL: cmd.op = tccs_pkg::OP_IGNORE;
                tccs_pkg::CHAR_BS:  cmd.op = tccs_pkg::OP_BACK;
                tccs_pkg::CHAR_LF:  cmd.op = tccs_pkg::OP_NEWLINE;
                default:            cmd.op = tccs_pkg::OP_PUT;
            endcase
        end
    end

    // No request is taken while the grid is being cleared.
    assign o_full = q_full || i_hold;
    assign q_push = i_push && !o_full;

    tccs_fifo #(
        .WIDTH ($bits(tccs_pkg::t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (cmd),
        .i_pop   (i_cmd_pop),
        .o_full  (q_full),
        .o_empty (o_cmd_empty),
        .o_data  (o_cmd)
    );

endmodule

@@ hw/rtl/tccs_back.sv @@
// Back stage: keeps the cursor and the character grid and carries out requests.
module tccs_back #(
    parameter int MAX_COLS = tccs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tccs_pkg::MAX_ROWS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_columns,
    input  logic [6:0]     i_rows,
    input  logic           i_cmd_empty,
    input  tccs_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_clearing,
    input  logic           i_res_pop,
    output logic           o_res_empty,
    output tccs_pkg::t_res o_res
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int NRW   = $clog2(MAX_ROWS + 1);
    localparam int NCW   = $clog2(MAX_COLS + 1);

    tccs_pkg::t_bstate r_state, n_state;
    logic [7:0]        r_col, n_col;
    logic [5:0]        r_row, n_row;
    logic [CW-1:0]     r_addr, n_addr;
    logic [CW-1:0]     r_end, n_end;
    logic              r_cp_valid, n_cp_valid;
    logic              r_pend, n_pend;
    logic [7:0]        r_code, n_code;
    logic              r_rd_ok, n_rd_ok;

    // Grid storage with a registered read port.
    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rd_data;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [7:0]        mem_wd;
    logic [AW-1:0]     mem_ra;

    logic [NRW-1:0]    e_rows;
    logic [NCW-1:0]    e_cols;
    logic [5:0]        row_inc;
    logic              need_scroll;
    logic              wrap;
    logic [5:0]        put_row;
    logic [7:0]        put_col;
    logic              put_in;
    logic [AW-1:0]     put_addr;
    logic              rd_in;
    logic [AW-1:0]     rd_addr;
    logic [CW-1:0]     scroll_end;
    logic [CW-1:0]     last_base;
    logic [CW-1:0]     cp_dst;
    logic [AW-1:0]     fin_addr;

    logic              res_push;
    logic              res_full;
    tccs_pkg::t_res    res;

    // Clamp the configured sizes to the storage.
    always_comb begin
        if (i_rows == '0) begin
            e_rows = NRW'(1);
        end else if (int'(i_rows) > MAX_ROWS) begin
            e_rows = NRW'(MAX_ROWS);
        end else begin
            e_rows = NRW'(i_rows);
        end
        if (i_columns == '0) begin
            e_cols = NCW'(1);
        end else if (int'(i_columns) > MAX_COLS) begin
            e_cols = NCW'(MAX_COLS);
        end else begin
            e_cols = NCW'(i_columns);
        end
    end

    // Cursor arithmetic and cell addresses.
    always_comb begin
        row_inc     = r_row + 6'd1;
        need_scroll = (int'(r_row) + 1) >= int'(e_rows);
        wrap        = int'(r_col) >= int'(e_cols);
        put_row     = wrap ? row_inc : r_row;
        put_col     = wrap ? 8'd0 : r_col;
        put_in      = (int'(put_row) < MAX_ROWS) && (int'(put_col) < MAX_COLS);
        put_addr    = AW'(int'(put_row) * MAX_COLS + int'(put_col));
        rd_in       = (int'(i_cmd.rrow) < MAX_ROWS) && (int'(i_cmd.rcol) < MAX_COLS);
        rd_addr     = AW'(int'(i_cmd.rrow) * MAX_COLS + int'(i_cmd.rcol));
        scroll_end  = CW'(int'(e_rows) * MAX_COLS);
        last_base   = CW'((int'(e_rows) - 1) * MAX_COLS);
        cp_dst      = r_addr - CW'(MAX_COLS + 1);
        fin_addr    = AW'(int'(r_row) * MAX_COLS);
    end

    // Sequencer: next state, memory control and result.
    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_addr     = r_addr;
        n_end      = r_end;
        n_cp_valid = r_cp_valid;
        n_pend     = r_pend;
        n_code     = r_code;
        n_rd_ok    = r_rd_ok;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = '0;
        mem_ra     = '0;
        o_cmd_pop  = 1'b0;
        res_push   = 1'b0;
        res        = '{col: r_col, row: r_row, glyph: 8'd0, scrolled: 1'b0};
        case (r_state)
            // Zero every cell once after reset.
            tccs_pkg::B_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_addr[AW-1:0];
                n_addr = CW'(r_addr + 1'b1);
                if (r_addr == CW'(DEPTH - 1)) begin
                    n_addr  = '0;
                    n_state = tccs_pkg::B_IDLE;
                end
            end
            tccs_pkg::B_IDLE: begin
                if (!i_cmd_empty && !res_full) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        tccs_pkg::OP_READ: begin
                            mem_ra  = rd_addr;
                            n_rd_ok = rd_in;
                            n_state = tccs_pkg::B_READ;
                        end
                        tccs_pkg::OP_BACK: begin
                            n_col    = (r_col != 8'd0) ? r_col - 8'd1 : 8'd0;
                            res_push = 1'b1;
                            res.col  = n_col;
                        end
                        tccs_pkg::OP_NEWLINE: begin
                            n_col = 8'd0;
                            if (need_scroll) begin
                                n_row      = 6'(e_rows - 1'b1);
                                n_addr     = CW'(MAX_COLS);
                                n_end      = scroll_end;
                                n_cp_valid = 1'b0;
                                n_pend     = 1'b0;
                                n_state    = tccs_pkg::B_SCROLL;
                            end else begin
                                n_row    = row_inc;
                                res_push = 1'b1;
                                res.col  = 8'd0;
                                res.row  = row_inc;
                            end
                        end
                        tccs_pkg::OP_PUT: begin
                            if (wrap && need_scroll) begin
                                // Scroll first; the byte is stored when it is done.
                                n_col      = 8'd0;
                                n_row      = 6'(e_rows - 1'b1);
                                n_addr     = CW'(MAX_COLS);
                                n_end      = scroll_end;
                                n_cp_valid = 1'b0;
                                n_pend     = 1'b1;
                                n_code     = i_cmd.code;
                                n_state    = tccs_pkg::B_SCROLL;
                            end else begin
                                mem_we   = put_in;
                                mem_wa   = put_addr;
                                mem_wd   = i_cmd.code;
                                n_col    = put_col + 8'd1;
                                n_row    = put_row;
                                res_push = 1'b1;
                                res.col  = n_col;
                                res.row  = put_row;
                            end
                        end
                        default: begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            // Read data is registered; return it in the cycle after the address is given.
            tccs_pkg::B_READ: begin
                res_push  = 1'b1;
                res.glyph = r_rd_ok ? r_rd_data : 8'd0;
                n_state   = tccs_pkg::B_IDLE;
            end
            // Copy each cell one row up: read this cycle, write the previous read.
            tccs_pkg::B_SCROLL: begin
                mem_we = r_cp_valid;
                mem_wa = cp_dst[AW-1:0];
                mem_wd = r_rd_data;
                if (r_addr < r_end) begin
                    mem_ra     = r_addr[AW-1:0];
                    n_addr     = CW'(r_addr + 1'b1);
                    n_cp_valid = 1'b1;
                end else begin
                    n_addr     = last_base;
                    n_cp_valid = 1'b0;
                    n_state    = tccs_pkg::B_WIPE;
                end
            end
            // Clear the bottom row in use.
            tccs_pkg::B_WIPE: begin
                mem_we = 1'b1;
                mem_wa = r_addr[AW-1:0];
                n_addr = CW'(r_addr + 1'b1);
                if (CW'(r_addr + 1'b1) == r_end) begin
                    n_state = tccs_pkg::B_FINISH;
                end
            end
            // Store a byte that waited for the scroll, if there is one, then report.
            tccs_pkg::B_FINISH: begin
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = fin_addr;
                    mem_wd = r_code;
                    n_col  = 8'd1;
                end
                n_pend       = 1'b0;
                res_push     = 1'b1;
                res.col      = n_col;
                res.scrolled = 1'b1;
                n_state      = tccs_pkg::B_IDLE;
            end
            default: begin
                n_state = tccs_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tccs_pkg::B_CLEAR;
            r_col      <= '0;
            r_row      <= '0;
            r_addr     <= '0;
            r_cp_valid <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_addr     <= n_addr;
            r_cp_valid <= n_cp_valid;
            r_pend     <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end   <= n_end;
        r_code  <= n_code;
        r_rd_ok <= n_rd_ok;
    end

    // Grid memory: one write and one read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    assign o_clearing = (r_state == tccs_pkg::B_CLEAR);

    tccs_fifo #(
        .WIDTH ($bits(tccs_pkg::t_res))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .i_pop   (i_res_pop),
        .o_full  (res_full),
        .o_empty (o_res_empty),
        .o_data  (o_res)
    );

endmodule

@@ hw/rtl/text_console_cursor_scroll.sv @@
// Top level of the text console: configuration registers, front and back stages.
//
//  Channel   Handshake               Payload
//  request   push / full             i_func, i_char_code, i_read_row, i_read_col
//  result    empty / pop             o_cursor_col, o_cursor_row, o_cell_char, o_scrolled
//  config    i_cfg_we                i_cfg_idx, i_cfg_data
//
// Appends and control characters are carried out by the back stage as it takes
// the request; reads return the cell through a separate state after the registered
// grid read. A newline or wrap that scrolls walks the grid one cell per cycle:
// it copies rows 1 to rows-1 up one row, wipes the bottom row in use and reports.
// After reset a clearing pass over all MAX_ROWS*MAX_COLS cells holds full high.
// Two-entry queues sit between front and back and on the result side, so each
// side stalls on its own.
module text_console_cursor_scroll #(
    parameter int MAX_COLS = tccs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tccs_pkg::MAX_ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_func,
    input  logic [7:0] i_char_code,
    input  logic [5:0] i_read_row,
    input  logic [6:0] i_read_col,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_cursor_col,
    output logic [5:0] o_cursor_row,
    output logic [7:0] o_cell_char,
    output logic       o_scrolled,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    logic [7:0]     r_columns;
    logic [6:0]     r_rows;
    logic           clearing;
    logic           cmd_pop;
    logic           cmd_empty;
    tccs_pkg::t_cmd cmd;
    tccs_pkg::t_res res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= tccs_pkg::COLUMNS_RST;
            r_rows    <= tccs_pkg::ROWS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tccs_pkg::REG_COLUMNS: r_columns <= i_cfg_data;
                tccs_pkg::REG_ROWS:    r_rows    <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    tccs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (clearing),
        .i_push      (push),
        .i_func      (i_func),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_full      (full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd_empty (cmd_empty),
        .o_cmd       (cmd)
    );

    tccs_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_columns   (r_columns),
        .i_rows      (r_rows),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_clearing  (clearing),
        .i_res_pop   (pop),
        .o_res_empty (empty),
        .o_res       (res)
    );

    // Result fields.
    assign o_cursor_col = res.col;
    assign o_cursor_row = res.row;
    assign o_cell_char  = res.glyph;
    assign o_scrolled   = res.scrolled;

endmodule
